### rtl/core/alist_pkg.sv
// Shared types and codes for the array list engine.
// Holds the request/response item structs, controller/datapath command and
// status structs, and the request and status codes. No dependencies.
package alist_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int ITEM_BITS_DEF = 32;
    localparam int ITEM_BITS_MAX = 64;

    localparam int VAL_W   = 32;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 7;
    localparam int KIND_W  = 3;
    localparam int STAT_W  = 2;

    localparam logic [KIND_W-1:0] REQ_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] REQ_UPDATE = 3'd1;
    localparam logic [KIND_W-1:0] REQ_DELETE = 3'd2;
    localparam logic [KIND_W-1:0] REQ_FIND   = 3'd3;
    localparam logic [KIND_W-1:0] REQ_GET    = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_POS  = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] req_type;
        logic [POS_W-1:0]  position;
        logic              append;
        logic [VAL_W-1:0]  item_value;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [POS_W-1:0]   position_out;
        logic [VAL_W-1:0]   item_out;
        logic [COUNT_W-1:0] item_count;
        logic               is_empty;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic              accept;
        logic              wr_val_pos;
        logic              wr_val_cnt;
        logic              rd_pos;
        logic              walk_init;
        logic              walk_rd;
        logic              walk_wr;
        logic              walk_stop;
        logic              cnt_inc;
        logic              cnt_dec;
        logic              st_load;
        logic [STAT_W-1:0] st_code;
        logic              pout_load;
        logic              res_load;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              app;
        logic              full;
        logic              pos_gt;
        logic              pos_ge;
        logic              pos_last;
        logic              cnt_zero;
        logic              rd_more;
        logic              lag_valid;
        logic              match;
        logic              slot_free;
    } dp_stat_t;

endpackage

### rtl/core/alist_dp.sv
// Datapath of the array list engine: entry memory, item count, walk pointer,
// read pipeline and the response register.
// Depends on alist_pkg; driven by alist_ctrl through ctrl_cmd_t.
module alist_dp #(
    parameter int CAPACITY  = alist_pkg::CAPACITY_DEF,
    parameter int ITEM_BITS = alist_pkg::ITEM_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  alist_pkg::req_t       req,
    input  alist_pkg::ctrl_cmd_t  cmd,
    output alist_pkg::dp_stat_t   stat,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output alist_pkg::rsp_t       rsp
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = CNT_W + alist_pkg::COUNT_W;
    localparam int WIDE_W = alist_pkg::ITEM_BITS_MAX;

    logic [ITEM_BITS-1:0] mem [CAPACITY];

    logic [alist_pkg::KIND_W-1:0] kind_reg;
    logic [alist_pkg::POS_W-1:0]  pos_reg;
    logic                         app_reg;
    logic [ITEM_BITS-1:0]         val_reg;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [ADDR_W-1:0] end_reg, end_next;
    logic              up_reg, up_next;
    logic              rd_more_reg, rd_more_next;
    logic              lag_valid_reg, lag_valid_next;
    logic [ADDR_W-1:0] lag_addr_reg;
    logic [ITEM_BITS-1:0] rd_data_reg;
    logic [alist_pkg::STAT_W-1:0] st_reg;
    logic [alist_pkg::POS_W-1:0]  pout_reg;
    logic              res_valid_reg, res_valid_next;
    alist_pkg::rsp_t   res_reg;

    logic [WIDE_W-1:0] val_wide;
    logic [WIDE_W-1:0] rd_wide;
    logic [CMP_W-1:0]  pos_x, cnt_x, cnt_m1, lag_x;
    logic [ADDR_W-1:0] pos_a, cnt_a;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_wa, mem_ra;
    logic [ITEM_BITS-1:0] mem_wd;
    alist_pkg::rsp_t   res_next;

    assign val_wide = WIDE_W'(req.item_value);
    assign rd_wide  = WIDE_W'(rd_data_reg);

    assign pos_x  = CMP_W'(pos_reg);
    assign cnt_x  = CMP_W'(cnt_reg);
    assign cnt_m1 = cnt_x - CMP_W'(1);
    assign lag_x  = CMP_W'(lag_addr_reg);
    assign pos_a  = pos_x[ADDR_W-1:0];
    assign cnt_a  = cnt_x[ADDR_W-1:0];

    // latched request
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg <= req.req_type;
            pos_reg  <= req.position;
            app_reg  <= req.append;
            val_reg  <= val_wide[ITEM_BITS-1:0];
        end
    end

    // memory ports: one write, one registered read
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = pos_a;
        mem_wd = val_reg;
        if (cmd.wr_val_pos)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.wr_val_cnt)
        begin
            mem_we = 1'b1;
            mem_wa = cnt_a;
        end
        else if (cmd.walk_wr && lag_valid_reg)
        begin
            mem_we = 1'b1;
            mem_wa = up_reg ? (lag_addr_reg - ADDR_W'(1)) : (lag_addr_reg + ADDR_W'(1));
            mem_wd = rd_data_reg;
        end
        mem_re = cmd.rd_pos | cmd.walk_rd;
        mem_ra = cmd.walk_rd ? ptr_reg : pos_a;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    // walk setup: insert moves down from the top, delete and find move up
    always_comb
    begin
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        end_next       = end_reg;
        up_next        = up_reg;
        rd_more_next   = rd_more_reg;
        lag_valid_next = cmd.walk_rd;

        if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end

        if (cmd.walk_init)
        begin
            rd_more_next = 1'b1;
            if (kind_reg == alist_pkg::REQ_INSERT)
            begin
                ptr_next = cnt_a - ADDR_W'(1);
                end_next = pos_a;
                up_next  = 1'b0;
            end
            else if (kind_reg == alist_pkg::REQ_DELETE)
            begin
                ptr_next = pos_a + ADDR_W'(1);
                end_next = cnt_m1[ADDR_W-1:0];
                up_next  = 1'b1;
            end
            else
            begin
                ptr_next = '0;
                end_next = cnt_m1[ADDR_W-1:0];
                up_next  = 1'b1;
            end
        end
        else if (cmd.walk_rd)
        begin
            ptr_next = up_reg ? (ptr_reg + ADDR_W'(1)) : (ptr_reg - ADDR_W'(1));
            if (ptr_reg == end_reg)
            begin
                rd_more_next = 1'b0;
            end
        end

        if (cmd.walk_stop)
        begin
            rd_more_next   = 1'b0;
            lag_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rd_more_reg   <= 1'b0;
            lag_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            rd_more_reg   <= rd_more_next;
            lag_valid_reg <= lag_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        end_reg <= end_next;
        up_reg  <= up_next;
        if (cmd.walk_rd)
        begin
            lag_addr_reg <= ptr_reg;
        end
        if (cmd.st_load)
        begin
            st_reg <= cmd.st_code;
        end
        if (cmd.pout_load)
        begin
            pout_reg <= lag_x[alist_pkg::POS_W-1:0];
        end
        if (cmd.res_load)
        begin
            res_reg <= res_next;
        end
    end

    // response item
    always_comb
    begin
        res_next.status       = st_reg;
        res_next.position_out = '0;
        res_next.item_out     = '0;
        res_next.item_count   = cnt_x[alist_pkg::COUNT_W-1:0];
        res_next.is_empty     = (cnt_reg == '0);
        if (st_reg == alist_pkg::ST_OK && kind_reg == alist_pkg::REQ_FIND)
        begin
            res_next.position_out = pout_reg;
        end
        if (st_reg == alist_pkg::ST_OK && kind_reg == alist_pkg::REQ_GET)
        begin
            res_next.item_out = rd_wide[alist_pkg::VAL_W-1:0];
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !rsp_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    assign rsp_valid = res_valid_reg;
    assign rsp       = res_reg;

    always_comb
    begin
        stat.kind      = kind_reg;
        stat.app       = app_reg;
        stat.full      = (cnt_reg == CNT_W'(CAPACITY));
        stat.pos_gt    = (pos_x > cnt_x);
        stat.pos_ge    = (pos_x >= cnt_x);
        stat.pos_last  = ((pos_x + CMP_W'(1)) == cnt_x);
        stat.cnt_zero  = (cnt_reg == '0);
        stat.rd_more   = rd_more_reg;
        stat.lag_valid = lag_valid_reg;
        stat.match     = lag_valid_reg && (rd_data_reg == val_reg);
        stat.slot_free = !res_valid_reg || !rsp_stall;
    end

endmodule

### rtl/core/alist_ctrl.sv
// Controller of the array list engine: request decode, walk sequencing and
// response hand-off. Depends on alist_pkg; drives alist_dp via ctrl_cmd_t.
module alist_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  alist_pkg::dp_stat_t   stat,
    output alist_pkg::ctrl_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       shift_op;

    assign req_stall = (state_reg != S_IDLE);
    assign shift_op  = (stat.kind == alist_pkg::REQ_INSERT)
                    || (stat.kind == alist_pkg::REQ_DELETE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.st_load = 1'b1;
                cmd.st_code = alist_pkg::ST_OK;
                state_next  = S_DONE;
                case (stat.kind)
                    alist_pkg::REQ_INSERT:
                    begin
                        // full check comes before the position check
                        if (stat.full)
                        begin
                            cmd.st_code = alist_pkg::ST_FULL;
                        end
                        else if (stat.app)
                        begin
                            cmd.wr_val_cnt = 1'b1;
                            cmd.cnt_inc    = 1'b1;
                        end
                        else if (stat.pos_gt)
                        begin
                            cmd.st_code = alist_pkg::ST_BAD_POS;
                        end
                        else if (stat.pos_ge)
                        begin
                            cmd.wr_val_pos = 1'b1;
                            cmd.cnt_inc    = 1'b1;
                        end
                        else
                        begin
                            cmd.st_load   = 1'b0;
                            cmd.walk_init = 1'b1;
                            state_next    = S_WALK;
                        end
                    end
                    alist_pkg::REQ_UPDATE:
                    begin
                        if (stat.pos_ge)
                        begin
                            cmd.st_code = alist_pkg::ST_BAD_POS;
                        end
                        else
                        begin
                            cmd.wr_val_pos = 1'b1;
                        end
                    end
                    alist_pkg::REQ_DELETE:
                    begin
                        if (stat.pos_ge)
                        begin
                            cmd.st_code = alist_pkg::ST_BAD_POS;
                        end
                        else if (stat.pos_last)
                        begin
                            cmd.cnt_dec = 1'b1;
                        end
                        else
                        begin
                            cmd.st_load   = 1'b0;
                            cmd.walk_init = 1'b1;
                            state_next    = S_WALK;
                        end
                    end
                    alist_pkg::REQ_FIND:
                    begin
                        if (stat.cnt_zero)
                        begin
                            cmd.st_code = alist_pkg::ST_NOTFOUND;
                        end
                        else
                        begin
                            cmd.st_load   = 1'b0;
                            cmd.walk_init = 1'b1;
                            state_next    = S_WALK;
                        end
                    end
                    alist_pkg::REQ_GET:
                    begin
                        if (stat.pos_ge)
                        begin
                            cmd.st_code = alist_pkg::ST_BAD_POS;
                        end
                        else
                        begin
                            cmd.rd_pos = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.st_code = alist_pkg::ST_BAD_POS;
                    end
                endcase
            end
            S_WALK:
            begin
                cmd.walk_wr = shift_op;
                if (stat.kind == alist_pkg::REQ_FIND && stat.match)
                begin
                    cmd.pout_load = 1'b1;
                    cmd.st_load   = 1'b1;
                    cmd.st_code   = alist_pkg::ST_OK;
                    cmd.walk_stop = 1'b1;
                    state_next    = S_DONE;
                end
                else if (!stat.rd_more && !stat.lag_valid)
                begin
                    // walk done (moves written back for insert/delete); finish the request
                    cmd.st_load = 1'b1;
                    cmd.st_code = alist_pkg::ST_OK;
                    state_next  = S_DONE;
                    if (stat.kind == alist_pkg::REQ_INSERT)
                    begin
                        cmd.wr_val_pos = 1'b1;
                        cmd.cnt_inc    = 1'b1;
                    end
                    else if (stat.kind == alist_pkg::REQ_DELETE)
                    begin
                        cmd.cnt_dec = 1'b1;
                    end
                    else
                    begin
                        cmd.st_code = alist_pkg::ST_NOTFOUND;
                    end
                end
                else
                begin
                    cmd.walk_rd = stat.rd_more;
                end
            end
            S_DONE:
            begin
                if (stat.slot_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/core/array_list_engine_core.sv
// Array list engine: ordered list of up to CAPACITY items with count.
// Channels: req (request item in) and rsp (result item out), each with
// valid/stall; an item moves on a rising edge with valid high, stall low.
// Every request gives exactly one result item.
// Update, get, append, insert at the count, delete of the last entry, find
// in an empty list and rejected requests go straight to the result; other
// inserts shift the entries from the position on up by one, other deletes
// shift those above it down by one, and find walks from entry zero until a
// match or the end of the list. The walk through the entry memory (one read
// port, one write port) moves one entry per cycle.
// One request is in work at a time; req_stall is high from accept until
// the result is placed in the output register, so the next request can be
// taken in the cycle after that.
// The output register holds a result while rsp_stall is high; the next
// request is taken meanwhile and waits before the output until it frees.
// Reset empties the list (count zero) and drops any pending result; entry
// contents are not cleared and are read only after being written.
module array_list_engine_core #(
    parameter int CAPACITY  = alist_pkg::CAPACITY_DEF,
    parameter int ITEM_BITS = alist_pkg::ITEM_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  alist_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output alist_pkg::rsp_t rsp
);

    alist_pkg::ctrl_cmd_t cmd;
    alist_pkg::dp_stat_t  stat;

    alist_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    alist_dp #(
        .CAPACITY  (CAPACITY),
        .ITEM_BITS (ITEM_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
